// ===== rtl/mbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Multichannel broadcast sequencer package
// Shared sizes, codes, the buffer write bundle and the channel search function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mbs_pkg;

  localparam int PAYLOAD_BYTES = 18;
  localparam int NUM_CHANNELS  = 16;
  localparam int CH_W          = 4;
  localparam int MASK_W        = 16;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int ADDR_W        = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
  localparam logic [CH_W-1:0] MAX_INDEX = CH_W'(NUM_CHANNELS - 1);

  localparam logic [1:0] CFG_LAST_INDEX      = 2'd0;
  localparam logic [1:0] CFG_CHANNEL_SPACING = 2'd1;
  localparam logic [1:0] CFG_HEARTBEAT_MS    = 2'd2;
  localparam logic [1:0] CFG_MAX_TRIES       = 2'd3;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_SEND = 2'd1;
  localparam logic [1:0] MODE_WAIT = 2'd2;

  localparam logic OP_HOST_BYTE = 1'b0;

  localparam logic [2:0] ACT_SEND_BYTE  = 3'd1;
  localparam logic [2:0] ACT_CHANGE_CH  = 3'd2;
  localparam logic [2:0] ACT_FLUSH      = 3'd3;
  localparam logic [2:0] ACT_REFUSED    = 3'd4;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mbs_wr_t;

  typedef struct packed {
    logic            found;
    logic            wrapped;
    logic [CH_W-1:0] idx;
  } mbs_find_t;

  // First set bit after start up to lim, else the first set bit from zero up to lim.
  function automatic mbs_find_t mbs_find(logic [MASK_W-1:0] mask, logic [CH_W-1:0] start,
                                         logic [CH_W-1:0] lim);
    mbs_find_t       res;
    logic            hi_f;
    logic            lo_f;
    logic [CH_W-1:0] hi_i;
    logic [CH_W-1:0] lo_i;
    hi_f = 1'b0;
    lo_f = 1'b0;
    hi_i = '0;
    lo_i = '0;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i] && (CH_W'(i) <= lim)) begin
        lo_f = 1'b1;
        lo_i = CH_W'(i);
        if (CH_W'(i) > start) begin
          hi_f = 1'b1;
          hi_i = CH_W'(i);
        end
      end
    end
    if (hi_f) begin
      res = '{found: 1'b1, wrapped: 1'b0, idx: hi_i};
    end else if (lo_f) begin
      res = '{found: 1'b1, wrapped: 1'b1, idx: lo_i};
    end else begin
      res = '{found: 1'b0, wrapped: 1'b1, idx: '0};
    end
    return res;
  endfunction

endpackage

// ===== rtl/multichannel_broadcast_sequencer.sv =====
// ----------------------------------------------------------------------------
// Multichannel broadcast sequencer
// Collects a host burst and replays it once on every live radio channel.
// ----------------------------------------------------------------------------
// Each input word is either a host byte or a service poll, told apart by
// in_tuser; in_tlast marks the end of a host burst. Result words carry an
// action code in out_tuser, and out_tlast marks the final word caused by one
// input. The cfg channel is always ready and writes one register per word.
// An input word is registered when taken and worked on in the following
// cycle. A word that causes no result lets the next one in after that work
// step, one with a single result once it enters the output register, which
// waits while the receiver holds out_tready low. A poll that replays the burst
// streams one byte per cycle from the payload memory while the receiver does
// not stall; the memory's registered read overlaps the output register, and
// the next word enters once the last stored byte is in the output register.
// The block takes no new input while results of the previous word are still
// being produced; a final word held in the output register does not block
// it. When the receiver stalls, the output register holds its word and the
// memory read stage holds the next byte. Reset returns the block to idle with
// all channels live, an empty burst and the register defaults; payload memory
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_broadcast_sequencer
  import mbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // host_byte [7:0], now_ms [39:8], tx_queue_empty [40], zero fill [47:41]
  input  logic [47:0] in_tdata,
  // op [0]
  input  logic        in_tuser,
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // value [7:0], live_mask [23:8]
  output logic [23:0] out_tdata,
  // action [2:0]
  output logic [2:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;
  localparam logic [1:0] S_ONE  = 2'd3;

  logic [CH_W-1:0]   last_index_r;
  logic [7:0]        spacing_r;
  logic [15:0]       heartbeat_ms_r;
  logic [7:0]        max_tries_r;

  logic [1:0]        state_r, state_nxt;
  logic [1:0]        mode_r, mode_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CH_W-1:0]   cur_r, cur_nxt;
  logic [CH_W-1:0]   sent_r, sent_nxt;
  logic [CH_W-1:0]   revive_r, revive_nxt;
  logic [MASK_W-1:0] alive_r, alive_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [7:0]        wait_r, wait_nxt;
  logic [31:0]       last_beat_r, last_beat_nxt;

  logic              op_r;
  logic [7:0]        byte_r;
  logic              end_r;
  logic              empty_r;

  logic [CNT_W-1:0]  send_idx_r, send_idx_nxt;
  logic              dv_r, dv_nxt;
  logic              dv_last_r, dv_last_nxt;

  logic [2:0]        res_act_r, res_act_nxt;
  logic [7:0]        res_val_r, res_val_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_val_r, out_val_nxt;
  logic [2:0]        out_act_r, out_act_nxt;
  logic              out_last_r, out_last_nxt;
  logic [MASK_W-1:0] out_mask_r, out_mask_nxt;

  logic              in_acc;
  logic [CH_W-1:0]   lim;
  logic [31:0]       beat_diff;
  mbs_find_t         rev_f;
  mbs_find_t         nxt_f;
  logic              slot_free;
  logic              load;
  logic              issue;
  logic              is_idle;
  logic [CNT_W-1:0]  count_inc;
  logic [7:0]        wait_inc;
  logic [11:0]       chan_prod;
  logic [7:0]        rd_data;
  mbs_wr_t           wr;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign lim       = (last_index_r > MAX_INDEX) ? MAX_INDEX : last_index_r;
  assign beat_diff = in_tdata[39:8] - last_beat_r;
  assign rev_f     = mbs_find(~alive_r, revive_r, lim);
  assign nxt_f     = mbs_find(alive_r, cur_r, lim);
  assign slot_free = !out_valid_r || out_tready;
  assign load      = (state_r == S_SEND) && dv_r && slot_free;
  assign issue     = (state_r == S_SEND) && (send_idx_r < count_r) && (!dv_r || load);
  assign is_idle   = (mode_r != MODE_SEND) && (mode_r != MODE_WAIT);
  assign count_inc = count_r + 1'b1;
  assign wait_inc  = wait_r + 1'b1;
  assign chan_prod = {8'b0, cur_r} * {4'b0, spacing_r};

  always_comb begin
    wr.en   = (state_r == S_EXEC) && (op_r == OP_HOST_BYTE) && is_idle &&
              (count_r < CNT_W'(PAYLOAD_BYTES));
    wr.addr = count_r[ADDR_W-1:0];
    wr.data = byte_r;
  end

  mbs_payload_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (issue),
    .rd_addr (send_idx_r[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    cur_nxt       = cur_r;
    sent_nxt      = sent_r;
    revive_nxt    = revive_r;
    alive_nxt     = alive_r;
    wrapped_nxt   = wrapped_r;
    wait_nxt      = wait_r;
    last_beat_nxt = last_beat_r;
    send_idx_nxt  = send_idx_r;
    dv_nxt        = dv_r;
    dv_last_nxt   = dv_last_r;
    res_act_nxt   = res_act_r;
    res_val_nxt   = res_val_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_val_nxt   = out_val_r;
    out_act_nxt   = out_act_r;
    out_last_nxt  = out_last_r;
    out_mask_nxt  = out_mask_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_EXEC;
          if (beat_diff > {16'b0, heartbeat_ms_r}) begin
            last_beat_nxt = in_tdata[39:8];
            if (rev_f.found) begin
              alive_nxt  = alive_r | (MASK_W'(1) << rev_f.idx);
              revive_nxt = rev_f.idx;
            end
          end
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        if (op_r == OP_HOST_BYTE) begin
          if (is_idle) begin
            if (count_r < CNT_W'(PAYLOAD_BYTES)) begin
              count_nxt = count_inc;
              mode_nxt  = (end_r || count_inc >= CNT_W'(PAYLOAD_BYTES)) ? MODE_SEND : MODE_IDLE;
            end else begin
              mode_nxt = MODE_SEND;
            end
          end else begin
            res_act_nxt = ACT_REFUSED;
            res_val_nxt = byte_r;
            state_nxt   = S_ONE;
          end
        end else if (is_idle) begin
          mode_nxt = (count_r != '0) ? MODE_SEND : MODE_IDLE;
        end else if (mode_r == MODE_SEND) begin
          sent_nxt     = cur_r;
          cur_nxt      = nxt_f.idx;
          wrapped_nxt  = wrapped_r | nxt_f.wrapped;
          mode_nxt     = MODE_WAIT;
          send_idx_nxt = '0;
          dv_nxt       = 1'b0;
          state_nxt    = S_SEND;
        end else if (empty_r) begin
          res_act_nxt = ACT_CHANGE_CH;
          res_val_nxt = chan_prod[7:0];
          wait_nxt    = '0;
          state_nxt   = S_ONE;
          if (wrapped_r) begin
            wrapped_nxt = 1'b0;
            mode_nxt    = MODE_IDLE;
            count_nxt   = '0;
          end else begin
            mode_nxt = MODE_SEND;
          end
        end else begin
          wait_nxt = wait_inc;
          if (wait_inc > max_tries_r) begin
            alive_nxt   = alive_r & ~(MASK_W'(1) << sent_r);
            res_act_nxt = ACT_FLUSH;
            res_val_nxt = '0;
            state_nxt   = S_ONE;
          end
        end
      end
      S_SEND: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = rd_data;
          out_act_nxt   = ACT_SEND_BYTE;
          out_last_nxt  = dv_last_r;
          out_mask_nxt  = alive_r;
        end
        if (issue) begin
          dv_nxt       = 1'b1;
          dv_last_nxt  = (CNT_W'(send_idx_r + 1'b1) == count_r);
          send_idx_nxt = send_idx_r + 1'b1;
        end else if (load) begin
          dv_nxt = 1'b0;
        end
        if ((send_idx_r == count_r) && (!dv_r || load)) begin
          state_nxt = S_IDLE;
        end
      end
      S_ONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_act_nxt   = res_act_r;
          out_last_nxt  = 1'b1;
          out_mask_nxt  = alive_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_index_r   <= 4'd15;
      spacing_r      <= 8'd17;
      heartbeat_ms_r <= 16'd500;
      max_tries_r    <= 8'd254;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LAST_INDEX:      last_index_r   <= cfg_data[CH_W-1:0];
        CFG_CHANNEL_SPACING: spacing_r      <= cfg_data[7:0];
        CFG_HEARTBEAT_MS:    heartbeat_ms_r <= cfg_data;
        CFG_MAX_TRIES:       max_tries_r    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= MODE_IDLE;
      count_r     <= '0;
      cur_r       <= '0;
      sent_r      <= '0;
      revive_r    <= 4'd15;
      alive_r     <= '1;
      wrapped_r   <= 1'b0;
      wait_r      <= '0;
      last_beat_r <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      cur_r       <= cur_nxt;
      sent_r      <= sent_nxt;
      revive_r    <= revive_nxt;
      alive_r     <= alive_nxt;
      wrapped_r   <= wrapped_nxt;
      wait_r      <= wait_nxt;
      last_beat_r <= last_beat_nxt;
      dv_r        <= dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_tuser;
      byte_r  <= in_tdata[7:0];
      end_r   <= in_tlast;
      empty_r <= in_tdata[40];
    end
    send_idx_r <= send_idx_nxt;
    dv_last_r  <= dv_last_nxt;
    res_act_r  <= res_act_nxt;
    res_val_r  <= res_val_nxt;
    out_val_r  <= out_val_nxt;
    out_act_r  <= out_act_nxt;
    out_last_r <= out_last_nxt;
    out_mask_r <= out_mask_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_mask_r, out_val_r};
  assign out_tuser  = out_act_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== rtl/mbs_payload_buf.sv =====
// ----------------------------------------------------------------------------
// Payload buffer
// Single-port-write, registered-read memory that holds one host burst.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mbs_payload_buf
  import mbs_pkg::*;
(
  input  logic              clk,
  input  mbs_wr_t           wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [PAYLOAD_BYTES];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
